// ----- sv/rgcd_pkg.sv -----
// Shared constants and types for the running GCD block.
package rgcd_pkg;

  localparam int FIELD_W     = 32;
  localparam int DATA_W_DEF  = 32;

  typedef logic [FIELD_W-1:0] field_t;

  // Control from the sequencer to the GCD core.
  typedef struct packed {
    logic start;
  } core_ctrl_t;

  // Status from the GCD core back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

endpackage

// ----- sv/rgcd_item_if.sv -----
// Input channel: one operand of the sequence and its last flag.
interface rgcd_item_if;
  import rgcd_pkg::*;

  logic   valid;
  logic   ready;
  field_t value;
  logic   last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// ----- sv/rgcd_result_if.sv -----
// Output channel: the divisor of a finished sequence.
interface rgcd_result_if;
  import rgcd_pkg::*;

  logic   valid;
  logic   ready;
  field_t divisor;

  modport source (output valid, output divisor, input ready);
  modport sink   (input valid, input divisor, output ready);
endinterface

// ----- sv/running_gcd_of_sequence.sv -----
// Running GCD of a sequence: each transaction on item folds its value into a
// running divisor; a transaction with last set also delivers the divisor of the
// whole sequence on result and clears the running divisor to zero. Only the low
// DATA_WIDTH bits of value are used. One item at a time is worked on: item is
// not ready again until the binary GCD core has finished; the core's single
// subtract-and-shift unit removes at least one bit from its two operands each
// cycle. A delivered result waits in an output register, so the next item is
// taken while it is pending; a last item that finishes while that register is
// still full keeps item low until the result channel takes the older divisor.
module running_gcd_of_sequence #(
  parameter int DATA_WIDTH = rgcd_pkg::DATA_W_DEF
) (
  input logic          clk,
  input logic          rst,
  rgcd_item_if.sink    item,
  rgcd_result_if.source result
);
  import rgcd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_EMIT
  } state_t;

  state_t                state;
  logic [DATA_WIDTH-1:0] acc;
  logic                  last_q;
  logic                  out_valid;
  field_t                out_divisor;
  core_ctrl_t            core_ctrl;
  core_stat_t            core_stat;
  logic [DATA_WIDTH-1:0] core_res;
  logic                  out_free;
  logic                  out_load;
  logic                  item_take;

  assign item.ready     = (state == S_IDLE);
  assign item_take      = item.valid && item.ready;
  assign core_ctrl.start = item_take;
  assign out_free       = !out_valid || result.ready;
  assign out_load       = ((state == S_RUN) && core_stat.done && last_q && out_free) ||
                          ((state == S_EMIT) && out_free);
  assign result.valid   = out_valid;
  assign result.divisor = out_divisor;

  rgcd_core #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .ctrl (core_ctrl),
    .a_in (acc),
    .b_in (DATA_WIDTH'(item.value)),
    .stat (core_stat),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      acc       <= '0;
      last_q    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && result.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_take) begin
            last_q <= item.last;
            state  <= S_RUN;
          end
        end
        S_RUN: begin
          if (core_stat.done) begin
            if (!last_q) begin
              acc   <= core_res;
              state <= S_IDLE;
            end else if (out_free) begin
              out_valid   <= 1'b1;
              out_divisor <= FIELD_W'(core_res);
              acc         <= '0;
              state       <= S_IDLE;
            end else begin
              // hold the divisor until the output register drains
              acc   <= core_res;
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_divisor <= FIELD_W'(acc);
            acc         <= '0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_take_idle_core: assert property (@(posedge clk) disable iff (rst)
    item_take |-> !core_stat.busy)
    else $error("item taken while the core is busy");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    core_stat.done |-> (state == S_RUN))
    else $error("core finished outside the run state");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) && out_free |=> (acc == '0) && out_valid)
    else $error("held divisor not delivered or accumulator not cleared");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    $past(item_take && !rst) |-> core_stat.busy && (state == S_RUN))
    else $error("core not started after a transaction");

endmodule

// ----- sv/rgcd_core.sv -----
// Iterative binary GCD core: one subtract-and-shift step per cycle.
module rgcd_core #(
  parameter int DATA_WIDTH = rgcd_pkg::DATA_W_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  rgcd_pkg::core_ctrl_t   ctrl,
  input  logic [DATA_WIDTH-1:0]  a_in,
  input  logic [DATA_WIDTH-1:0]  b_in,
  output rgcd_pkg::core_stat_t   stat,
  output logic [DATA_WIDTH-1:0]  res
);
  import rgcd_pkg::*;

  localparam int KW = $clog2(DATA_WIDTH + 1);

  logic                  running;
  logic                  done;
  logic [DATA_WIDTH-1:0] a;
  logic [DATA_WIDTH-1:0] b;
  logic [KW-1:0]         k;
  logic                  a_zero;
  logic                  b_zero;
  logic                  finish;
  logic [DATA_WIDTH:0]   d_ab;
  logic [DATA_WIDTH-1:0] d_ba;
  logic [DATA_WIDTH-1:0] a_next;
  logic [DATA_WIDTH-1:0] b_next;
  logic [KW-1:0]         k_next;
  logic [DATA_WIDTH-1:0] res_next;

  assign a_zero = (a == '0);
  assign b_zero = (b == '0);
  assign finish = running && (a_zero || b_zero);
  assign d_ab   = {1'b0, a} - {1'b0, b};
  assign d_ba   = b - a;

  // One step of the shared unit; gcd(a, b) << k is kept invariant.
  always_comb begin
    a_next   = a;
    b_next   = b;
    k_next   = k;
    res_next = a_zero ? (b << k) : (a << k);
    priority if (!a[0] && !b[0]) begin
      a_next = a >> 1;
      b_next = b >> 1;
      k_next = k + KW'(1);
    end else if (!a[0]) begin
      a_next = a >> 1;
    end else if (!b[0]) begin
      b_next = b >> 1;
    end else if (!d_ab[DATA_WIDTH]) begin
      a_next = d_ab[DATA_WIDTH-1:0] >> 1;
    end else begin
      b_next = d_ba >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        running <= 1'b1;
      end else if (finish) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      a <= a_in;
      b <= b_in;
      k <= '0;
    end else if (finish) begin
      res <= res_next;
    end else if (running) begin
      a <= a_next;
      b <= b_next;
      k <= k_next;
    end
  end

  assign stat.busy = running || done;
  assign stat.done = done;

endmodule
